/* design/oref_pkg.sv */
// shared types and constants for the object record deframer
// no dependencies; used by design/object_record_deframer.sv
package oref_pkg;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SENT1 = 3'd1,
    PH_CNTLO = 3'd2,
    PH_CNTHI = 3'd3,
    PH_DATA  = 3'd4,
    PH_CKSUM = 3'd5,
    PH_PAD   = 3'd6
  } phase_t;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_GOOD  = 3'd1;
  localparam logic [2:0] KIND_BAD   = 3'd2;
  localparam logic [2:0] KIND_SHORT = 3'd3;
  localparam logic [2:0] KIND_TERM  = 3'd4;

  localparam logic FMT_LENGTH   = 1'b0;
  localparam logic FMT_CHECKSUM = 1'b1;

  localparam logic [15:0] HEADER_BYTES = 16'd4;
  localparam logic [7:0]  SENTINEL_LO  = 8'h01;
  localparam logic [7:0]  SENTINEL_HI  = 8'h00;

endpackage

/* design/object_record_deframer.sv */
// object record deframer: splits an object-file byte stream into records
// depends on design/oref_pkg.sv
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+---------------------------
//  cfg     | cfg_valid cfg_ready cfg_data              | in  | frame_format, clears state
//  in      | in_valid in_ready in_byte                 | in  | one byte per transaction
//  out     | out_valid out_ready data_byte kind        | out | zero or one result per byte
//          | end_of_record record_length               |     |
//
// one byte per cycle while in_ready is high: state and result register update in the cycle a byte is taken
// a result appears on out in the cycle after its byte is taken
// in_ready drops only while a result waits and out_ready is low
// rst is synchronous; it sets length-prefixed format and clears all framing state
// a cfg transaction (any value) drops the record in progress
module object_record_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [2:0]  kind,
  output logic        end_of_record,
  output logic [15:0] record_length
);

  logic               frame_format;
  oref_pkg::phase_t   phase, phase_next;
  logic [7:0]         count_low_byte, count_low_byte_next;
  logic [15:0]        remaining_bytes, remaining_bytes_next;
  logic [15:0]        payload_length, payload_length_next;
  logic [7:0]         running_sum, running_sum_next;
  logic               pad_pending, pad_pending_next;

  logic               in_fire, cfg_fire;
  logic               res_emit;
  logic [7:0]         res_data;
  logic [2:0]         res_kind;
  logic               res_eor;
  logic [15:0]        res_len;
  logic [15:0]        count;
  logic [15:0]        rem_dec;
  logic [7:0]         sum_add;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign count   = {in_byte, count_low_byte};
  assign rem_dec = remaining_bytes - 16'd1;
  assign sum_add = running_sum + in_byte;

  always_comb begin
    phase_next           = phase;
    count_low_byte_next  = count_low_byte;
    remaining_bytes_next = remaining_bytes;
    payload_length_next  = payload_length;
    running_sum_next     = running_sum;
    pad_pending_next     = pad_pending;
    res_emit = 1'b0;
    res_data = 8'd0;
    res_kind = oref_pkg::KIND_DATA;
    res_eor  = 1'b0;
    res_len  = 16'd0;

    if (frame_format == oref_pkg::FMT_CHECKSUM) begin
      unique case (phase)
        oref_pkg::PH_START: begin
          if (in_byte == oref_pkg::SENTINEL_LO) phase_next = oref_pkg::PH_SENT1;
        end
        oref_pkg::PH_SENT1: begin
          // a repeated 01 may itself start the sentinel
          if (in_byte == oref_pkg::SENTINEL_HI) phase_next = oref_pkg::PH_CNTLO;
          else if (in_byte != oref_pkg::SENTINEL_LO) phase_next = oref_pkg::PH_START;
        end
        oref_pkg::PH_CNTLO: begin
          count_low_byte_next = in_byte;
          phase_next          = oref_pkg::PH_CNTHI;
        end
        oref_pkg::PH_CNTHI: begin
          if (count < oref_pkg::HEADER_BYTES) begin
            phase_next           = oref_pkg::PH_START;
            count_low_byte_next  = 8'd0;
            remaining_bytes_next = 16'd0;
            payload_length_next  = 16'd0;
            running_sum_next     = 8'd0;
            pad_pending_next     = 1'b0;
            res_emit = 1'b1;
            res_kind = oref_pkg::KIND_SHORT;
            res_eor  = 1'b1;
          end else begin
            payload_length_next  = count - oref_pkg::HEADER_BYTES;
            remaining_bytes_next = count - oref_pkg::HEADER_BYTES;
            // sentinel bytes sum to 1
            running_sum_next     = 8'd1 + count_low_byte + in_byte;
            phase_next = (count == oref_pkg::HEADER_BYTES) ? oref_pkg::PH_CKSUM
                                                            : oref_pkg::PH_DATA;
          end
        end
        oref_pkg::PH_DATA: begin
          running_sum_next     = sum_add;
          remaining_bytes_next = rem_dec;
          if (rem_dec == 16'd0) phase_next = oref_pkg::PH_CKSUM;
          res_emit = 1'b1;
          res_data = in_byte;
          res_len  = payload_length;
        end
        oref_pkg::PH_CKSUM: begin
          res_emit = 1'b1;
          res_kind = (sum_add == 8'd0) ? oref_pkg::KIND_GOOD : oref_pkg::KIND_BAD;
          res_eor  = 1'b1;
          res_len  = payload_length;
          phase_next           = oref_pkg::PH_START;
          count_low_byte_next  = 8'd0;
          remaining_bytes_next = 16'd0;
          payload_length_next  = 16'd0;
          running_sum_next     = 8'd0;
          pad_pending_next     = 1'b0;
        end
        default: begin
          phase_next           = oref_pkg::PH_START;
          count_low_byte_next  = 8'd0;
          remaining_bytes_next = 16'd0;
          payload_length_next  = 16'd0;
          running_sum_next     = 8'd0;
          pad_pending_next     = 1'b0;
        end
      endcase
    end else begin
      unique case (phase)
        oref_pkg::PH_START: begin
          count_low_byte_next = in_byte;
          phase_next          = oref_pkg::PH_CNTHI;
        end
        oref_pkg::PH_CNTHI: begin
          if (count == 16'd0) begin
            phase_next           = oref_pkg::PH_START;
            count_low_byte_next  = 8'd0;
            remaining_bytes_next = 16'd0;
            payload_length_next  = 16'd0;
            running_sum_next     = 8'd0;
            pad_pending_next     = 1'b0;
            res_emit = 1'b1;
            res_kind = oref_pkg::KIND_TERM;
            res_eor  = 1'b1;
          end else begin
            payload_length_next  = count;
            remaining_bytes_next = count;
            pad_pending_next     = count[0];
            phase_next           = oref_pkg::PH_DATA;
          end
        end
        oref_pkg::PH_DATA: begin
          remaining_bytes_next = rem_dec;
          res_emit = 1'b1;
          res_data = in_byte;
          res_len  = payload_length;
          if (rem_dec == 16'd0) begin
            res_eor = 1'b1;
            if (pad_pending) begin
              phase_next = oref_pkg::PH_PAD;
            end else begin
              phase_next           = oref_pkg::PH_START;
              count_low_byte_next  = 8'd0;
              payload_length_next  = 16'd0;
              running_sum_next     = 8'd0;
              pad_pending_next     = 1'b0;
            end
          end
        end
        default: begin
          // pad byte, or a phase the length-prefixed format never uses
          phase_next           = oref_pkg::PH_START;
          count_low_byte_next  = 8'd0;
          remaining_bytes_next = 16'd0;
          payload_length_next  = 16'd0;
          running_sum_next     = 8'd0;
          pad_pending_next     = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_fire) begin
      frame_format    <= rst ? oref_pkg::FMT_LENGTH : cfg_data;
      phase           <= oref_pkg::PH_START;
      count_low_byte  <= 8'd0;
      remaining_bytes <= 16'd0;
      payload_length  <= 16'd0;
      running_sum     <= 8'd0;
      pad_pending     <= 1'b0;
    end else if (in_fire) begin
      phase           <= phase_next;
      count_low_byte  <= count_low_byte_next;
      remaining_bytes <= remaining_bytes_next;
      payload_length  <= payload_length_next;
      running_sum     <= running_sum_next;
      pad_pending     <= pad_pending_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && !cfg_fire && res_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_emit) begin
      data_byte     <= res_data;
      kind          <= res_kind;
      end_of_record <= res_eor;
      record_length <= res_len;
    end
  end

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> phase == oref_pkg::PH_START)
    else $error("framing state not cleared after format write");

  a_status_ends_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != oref_pkg::KIND_DATA |-> end_of_record)
    else $error("status result without end of record");

  a_short_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == oref_pkg::KIND_SHORT || kind == oref_pkg::KIND_TERM)
      |-> record_length == 16'd0 && data_byte == 8'd0)
    else $error("short or terminator result carries length or data");

  a_pad_length_mode: assert property (@(posedge clk) disable iff (rst)
    phase == oref_pkg::PH_PAD || pad_pending |-> frame_format == oref_pkg::FMT_LENGTH)
    else $error("pad state in checksummed format");

  a_sentinel_phases: assert property (@(posedge clk) disable iff (rst)
    phase == oref_pkg::PH_SENT1 || phase == oref_pkg::PH_CNTLO || phase == oref_pkg::PH_CKSUM
      |-> frame_format == oref_pkg::FMT_CHECKSUM)
    else $error("checksum phase in length-prefixed format");

endmodule
